### rtl/asau_pkg.sv
// shared constants, types and codes for the aligned stack allocator
package asau_pkg;

    // sizing of the allocator
    localparam int HEADER_BYTES    = 16;
    localparam int MAX_LIVE        = 64;
    localparam int MAX_ALIGN_BYTES = 128;

    // field widths
    localparam int ADDR_W = 32;
    localparam int OFF_W  = 21;
    localparam int LG_W   = 4;
    localparam int STAT_W = 2;

    // derived widths
    localparam int ALIGN_LOG2_MAX = $clog2(MAX_ALIGN_BYTES);
    localparam int LOW_W          = ALIGN_LOG2_MAX + 1;
    localparam int PAD_W          = $clog2(HEADER_BYTES + MAX_ALIGN_BYTES);
    localparam int SUM_W          = PAD_W + 1;
    localparam int CNT_W          = $clog2(MAX_LIVE + 1);
    localparam int TOT_W          = OFF_W + 2;

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_BYTES = 1'b1;
    localparam logic [OFF_W-1:0]     CAPACITY_RESET     = 21'd65536;

    // action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_POP   = 1'b1;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_NOMEM = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // shift control broadcast along the offset stack cells
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_ctl;

endpackage

### rtl/aligned_stack_allocator_unit.sv
// top level: aligned LIFO allocator with a shifting chain of saved offsets
// Each transaction is accepted in idle, the header
// padding is worked out from the current address in the next cycle, and the result is
// committed and registered in the commit state, which waits while a held result is still
// stalled; the sequencer is back in idle in the cycle after commit, so no new transaction
// is accepted before the last one commits. A finished result waits in the output register
// and does not block the next transaction until its own commit.
// Saved offsets live in a chain of MAX_LIVE cells; a push or pop shifts every cell
// one place in the commit cycle, so the newest saved offset is always at the head.
// Configuration is written through a plain write port and must only change while
// no transaction is in flight.
module aligned_stack_allocator_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration port
    input  logic                                   i_cfg_we,
    input  logic [asau_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [asau_pkg::ADDR_W-1:0]            i_cfg_wdata,
    // request channel
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_action,
    input  logic [asau_pkg::OFF_W-1:0]             i_request_bytes,
    input  logic [asau_pkg::LG_W-1:0]              i_align_log2,
    // result channel
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [asau_pkg::STAT_W-1:0]            o_status,
    output logic [asau_pkg::ADDR_W-1:0]            o_granted_address,
    output logic [asau_pkg::OFF_W-1:0]             o_used_bytes
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_COMMIT
    } t_state;

    t_state                          r_state;
    logic [asau_pkg::ADDR_W-1:0]     r_base;
    logic [asau_pkg::OFF_W-1:0]      r_capacity;
    logic [asau_pkg::OFF_W-1:0]      r_top;
    logic [asau_pkg::CNT_W-1:0]      r_live;
    logic                            r_action;
    logic [asau_pkg::OFF_W-1:0]      r_size;
    logic [asau_pkg::LG_W-1:0]       r_lg;
    logic [asau_pkg::ADDR_W-1:0]     r_addr;
    logic [asau_pkg::PAD_W-1:0]      r_pad;
    logic                            r_out_valid;
    asau_pkg::t_status               r_status;
    logic [asau_pkg::ADDR_W-1:0]     r_granted;
    logic [asau_pkg::OFF_W-1:0]      r_used;

    logic [asau_pkg::ADDR_W-1:0]     n_addr;
    logic [asau_pkg::LG_W-1:0]       n_lg_clamp;
    logic [asau_pkg::SUM_W-1:0]      n_mask;
    logic [asau_pkg::SUM_W-1:0]      n_addr_mod;
    logic [asau_pkg::SUM_W-1:0]      n_round;
    logic [asau_pkg::SUM_W-1:0]      n_pad_full;
    logic [asau_pkg::TOT_W-1:0]      n_total;
    logic                            n_fits;
    logic                            n_full;
    logic                            n_empty;
    logic                            n_commit;
    asau_pkg::t_status               n_status;
    asau_pkg::t_shift_ctl            n_ctl;
    logic [asau_pkg::OFF_W-1:0]      w_stack_head;
    logic [asau_pkg::OFF_W-1:0]      w_cell [asau_pkg::MAX_LIVE];

    // padding: round current address plus header up to the alignment
    always_comb begin
        n_addr     = r_base + asau_pkg::ADDR_W'(r_top);
        n_lg_clamp = (r_lg > asau_pkg::LG_W'(asau_pkg::ALIGN_LOG2_MAX))
                   ? asau_pkg::LG_W'(asau_pkg::ALIGN_LOG2_MAX) : r_lg;
        n_mask     = (asau_pkg::SUM_W'(1) << n_lg_clamp) - asau_pkg::SUM_W'(1);
        n_addr_mod = asau_pkg::SUM_W'(n_addr[asau_pkg::LOW_W-1:0]) & n_mask;
        n_round    = (n_addr_mod + asau_pkg::SUM_W'(asau_pkg::HEADER_BYTES) + n_mask)
                   & ~n_mask;
        n_pad_full = n_round - n_addr_mod;
    end

    // commit decision
    always_comb begin
        n_total  = asau_pkg::TOT_W'(r_top) + asau_pkg::TOT_W'(r_size)
                 + asau_pkg::TOT_W'(r_pad);
        n_fits   = n_total < asau_pkg::TOT_W'(r_capacity);
        n_full   = r_live == asau_pkg::CNT_W'(asau_pkg::MAX_LIVE);
        n_empty  = r_live == '0;
        n_commit = (r_state == S_COMMIT) && (!r_out_valid || !i_stall);
        n_status = asau_pkg::ST_OK;
        if (r_action == asau_pkg::ACT_ALLOC) begin
            if (n_full) begin
                n_status = asau_pkg::ST_FULL;
            end else if (!n_fits) begin
                n_status = asau_pkg::ST_NOMEM;
            end
        end else if (n_empty) begin
            n_status = asau_pkg::ST_EMPTY;
        end
        n_ctl.push = n_commit && (r_action == asau_pkg::ACT_ALLOC)
                   && (n_status == asau_pkg::ST_OK);
        n_ctl.pop  = n_commit && (r_action == asau_pkg::ACT_POP)
                   && (n_status == asau_pkg::ST_OK);
    end

    // chain of saved offset cells, head holds the newest entry
    genvar g;
    generate
        for (g = 0; g < asau_pkg::MAX_LIVE; g++) begin : g_cell
            logic [asau_pkg::OFF_W-1:0] w_upper;
            logic [asau_pkg::OFF_W-1:0] w_lower;
            if (g == 0) begin : g_head
                assign w_upper = r_top;
            end else begin : g_mid
                assign w_upper = w_cell[g-1];
            end
            if (g == asau_pkg::MAX_LIVE - 1) begin : g_tail
                assign w_lower = w_cell[g];
            end else begin : g_body
                assign w_lower = w_cell[g+1];
            end
            asau_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (n_ctl),
                .i_from_upper (w_upper),
                .i_from_lower (w_lower),
                .o_value      (w_cell[g])
            );
        end
    endgenerate

    assign w_stack_head = w_cell[0];

    // sequencer, allocator state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_capacity  <= asau_pkg::CAPACITY_RESET;
            r_top       <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    asau_pkg::REG_BASE_ADDRESS:   r_base     <= i_cfg_wdata;
                    asau_pkg::REG_CAPACITY_BYTES: r_capacity <= i_cfg_wdata[asau_pkg::OFF_W-1:0];
                    default: ;
                endcase
            end
            // result register fills on commit, empties when taken downstream
            if (n_commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_action <= i_action;
                        r_size   <= i_request_bytes;
                        r_lg     <= i_align_log2;
                        r_state  <= S_PAD;
                    end
                end
                S_PAD: begin
                    r_addr  <= n_addr;
                    r_pad   <= n_pad_full[asau_pkg::PAD_W-1:0];
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (n_commit) begin
                        r_status <= n_status;
                        if (n_ctl.push) begin
                            r_top     <= n_total[asau_pkg::OFF_W-1:0];
                            r_live    <= r_live + asau_pkg::CNT_W'(1);
                            r_granted <= r_addr + asau_pkg::ADDR_W'(r_pad);
                            r_used    <= n_total[asau_pkg::OFF_W-1:0];
                        end else if (n_ctl.pop) begin
                            r_top     <= w_stack_head;
                            r_live    <= r_live - asau_pkg::CNT_W'(1);
                            r_granted <= '0;
                            r_used    <= w_stack_head;
                        end else begin
                            r_granted <= '0;
                            r_used    <= r_top;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_status          = r_status;
    assign o_granted_address = r_granted;
    assign o_used_bytes      = r_used;

endmodule

### rtl/asau_cell.sv
// one entry of the offset stack, shifting toward its neighbors on push or pop
module asau_cell (
    input  logic                    i_clk,
    input  asau_pkg::t_shift_ctl    i_ctl,
    input  logic [asau_pkg::OFF_W-1:0] i_from_upper,
    input  logic [asau_pkg::OFF_W-1:0] i_from_lower,
    output logic [asau_pkg::OFF_W-1:0] o_value
);

    logic [asau_pkg::OFF_W-1:0] r_value;
    logic [asau_pkg::OFF_W-1:0] n_value;

    // push takes the entry above, pop takes the entry below
    always_comb begin
        n_value = r_value;
        if (i_ctl.push) begin
            n_value = i_from_upper;
        end else if (i_ctl.pop) begin
            n_value = i_from_lower;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

### rtl/asau_checker.sv
// port-level checks for the aligned stack allocator, bound to the top level
module asau_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [asau_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [asau_pkg::ADDR_W-1:0]    i_cfg_wdata,
    input  logic                           i_valid,
    input  logic                           o_stall,
    input  logic                           i_action,
    input  logic [asau_pkg::OFF_W-1:0]     i_request_bytes,
    input  logic [asau_pkg::LG_W-1:0]      i_align_log2,
    input  logic                           o_valid,
    input  logic                           i_stall,
    input  logic [asau_pkg::STAT_W-1:0]    o_status,
    input  logic [asau_pkg::ADDR_W-1:0]    o_granted_address,
    input  logic [asau_pkg::OFF_W-1:0]     o_used_bytes
);

    // refused transactions never grant an address; pops grant none either but are not checked here
    a_no_grant_on_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != asau_pkg::ST_OK) |-> o_granted_address == '0)
        else $error("address granted on a refused transaction");

    // a request is worked on in the pad and commit states, so the port stalls after accepting
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request port did not stall after accepting");

    // no result is shown right after reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a held result keeps its payload
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)
            && $stable(o_granted_address) && $stable(o_used_bytes))
        else $error("held result changed");

endmodule

bind aligned_stack_allocator_unit asau_checker u_asau_checker (.*);

### verif/aligned_stack_allocator_unit_test.sv
// testbench for the aligned stack allocator: directed and random transactions
`timescale 1ns / 100ps

module aligned_stack_allocator_unit_test;
    import asau_pkg::*;

    localparam int LIMIT_CYCLES   = 250000;

    // expected result of one transaction
    typedef struct packed {
        t_status              status;
        logic [ADDR_W-1:0]    address;
        logic [OFF_W-1:0]     used;
    } t_alloc_result;

    // receiver stall behaviors
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    // dut ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_BASE_ADDRESS;
    logic [ADDR_W-1:0]     i_cfg_wdata = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_action = ACT_ALLOC;
    logic [OFF_W-1:0]      i_request_bytes = '0;
    logic [LG_W-1:0]       i_align_log2 = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [STAT_W-1:0]     o_status;
    logic [ADDR_W-1:0]     o_granted_address;
    logic [OFF_W-1:0]      o_used_bytes;

    // allocator state as the testbench sees it
    logic [ADDR_W-1:0]     base_reg;
    logic [OFF_W-1:0]      cap_reg;
    logic [OFF_W-1:0]      top_off;
    logic [OFF_W-1:0]      saved_off [MAX_LIVE];
    int                    live_depth;

    t_alloc_result         pending_results [$];
    int                    errors = 0;
    int                    n_sent = 0;
    int                    n_checked = 0;
    int                    status_seen [4] = '{0, 0, 0, 0};
    int                    cycle_count = 0;
    int                    burst_left = 0;
    t_stall_mode           stall_mode = STALL_NONE;
    int                    stall_left = 0;

    aligned_stack_allocator_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_action          (i_action),
        .i_request_bytes   (i_request_bytes),
        .i_align_log2      (i_align_log2),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_granted_address (o_granted_address),
        .o_used_bytes      (o_used_bytes)
    );

    // clock
    always #6 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    // receiver stall pattern, switching between random stall behaviors
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:     i_stall <= 1'b0;
            STALL_LIGHT:    i_stall <= ($urandom_range(0, 99) < 25);
            STALL_HEAVY:    i_stall <= ($urandom_range(0, 99) < 75);
            STALL_PERIODIC: i_stall <= (stall_left % 4 == 0);
            default:        i_stall <= 1'b0;
        endcase
    end

    // alignment requested by align_log2, clamped to the maximum
    function automatic longint unsigned align_bytes(logic [LG_W-1:0] lg);
        if (lg > ALIGN_LOG2_MAX)
            return MAX_ALIGN_BYTES;
        return 64'd1 << lg;
    endfunction

    // padding up to an aligned address with room for the header below it
    function automatic longint unsigned header_pad(longint unsigned addr,
                                                   longint unsigned align);
        longint unsigned rem;
        longint unsigned pad;
        rem = addr & (align - 1);
        pad = (rem != 0) ? align - rem : 0;
        if (pad < HEADER_BYTES)
            pad += align * ((HEADER_BYTES - pad + align - 1) / align);
        return pad;
    endfunction

    // works out the result of one transaction and advances the allocator state
    function automatic t_alloc_result compute_allocation(logic act, logic [OFF_W-1:0] bytes,
                                                         logic [LG_W-1:0] lg);
        t_alloc_result   r;
        longint unsigned align;
        longint unsigned cur_addr;
        longint unsigned pad;
        r.status  = ST_OK;
        r.address = '0;
        if (act == ACT_ALLOC) begin
            align = align_bytes(lg);
            if (live_depth >= MAX_LIVE) begin
                r.status = ST_FULL;
            end else begin
                cur_addr = longint'(base_reg) + longint'(top_off);
                pad = header_pad(cur_addr, align);
                if (longint'(top_off) + longint'(bytes) + pad >= longint'(cap_reg)) begin
                    r.status = ST_NOMEM;
                end else begin
                    saved_off[live_depth] = top_off;
                    live_depth++;
                    top_off = OFF_W'(longint'(top_off) + pad + longint'(bytes));
                    r.address = ADDR_W'(cur_addr + pad);
                end
            end
        end else begin
            if (live_depth == 0) begin
                r.status = ST_EMPTY;
            end else begin
                live_depth--;
                top_off = saved_off[live_depth];
            end
        end
        r.used = top_off;
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_alloc_result exp;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, status %0d address %h used %0d",
                         $time, o_status, o_granted_address, o_used_bytes);
            end else begin
                exp = pending_results.pop_front();
                n_checked++;
                status_seen[exp.status]++;
                if (o_status !== exp.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp.status, o_status);
                end
                if (o_granted_address !== exp.address) begin
                    errors++;
                    $display("%0t: granted_address expected %h actual %h",
                             $time, exp.address, o_granted_address);
                end
                if (o_used_bytes !== exp.used) begin
                    errors++;
                    $display("%0t: used_bytes expected %0d actual %0d",
                             $time, exp.used, o_used_bytes);
                end
            end
        end
    end

    // one request transaction, with bursts and random gaps on the sender side
    task automatic send_request(input logic act, input logic [OFF_W-1:0] bytes,
                                input logic [LG_W-1:0] lg);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_valid         <= 1'b1;
        i_action        <= act;
        i_request_bytes <= bytes;
        i_align_log2    <= lg;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(compute_allocation(act, bytes, lg));
        n_sent++;
        burst_left--;
    endtask

    // sender pauses until every expected result has arrived
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // register write while the block is idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [ADDR_W-1:0] data);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_BASE_ADDRESS)
            base_reg = data;
        else
            cap_reg = data[OFF_W-1:0];
    endtask

    task automatic apply_reset();
        base_reg   = '0;
        cap_reg    = CAPACITY_RESET;
        top_off    = '0;
        live_depth = 0;
        i_rst_n <= 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    task automatic test_pop_on_empty();
        send_request(ACT_POP, '1, '1);
        send_request(ACT_POP, '0, '0);
    endtask

    // alignments below, at and above the clamp
    task automatic test_alignment_clamp();
        send_request(ACT_ALLOC, 21'd1, 4'd0);
        send_request(ACT_ALLOC, 21'd3, 4'd1);
        send_request(ACT_ALLOC, 21'd0, 4'd4);
        send_request(ACT_ALLOC, 21'd7, 4'd5);
        send_request(ACT_ALLOC, 21'd13, 4'd7);
        send_request(ACT_ALLOC, 21'd5, 4'd8);
        send_request(ACT_ALLOC, 21'd100, 4'd15);
    endtask

    // request that just reaches capacity is refused, one byte less fits
    task automatic test_capacity_edge();
        longint unsigned pad;
        longint unsigned room;
        pad  = header_pad(longint'(base_reg) + longint'(top_off), align_bytes(4'd4));
        room = longint'(cap_reg) - longint'(top_off) - pad;
        send_request(ACT_ALLOC, OFF_W'(room), 4'd4);
        send_request(ACT_ALLOC, OFF_W'(room - 1), 4'd4);
        send_request(ACT_ALLOC, '1, 4'd2);
        send_request(ACT_POP, 21'd0, 4'd0);
    endtask

    // aligned address wraps past the top of the address space
    task automatic test_address_wrap();
        write_register(REG_BASE_ADDRESS, 32'hFFFF_FFF5);
        write_register(REG_CAPACITY_BYTES, 32'd1048576);
        send_request(ACT_ALLOC, 21'd10, 4'd7);
        send_request(ACT_ALLOC, 21'd0, 4'd2);
        send_request(ACT_POP, 21'd0, 4'd0);
    endtask

    // capacity lowered under the current offset: allocates refused, pops still work
    task automatic test_capacity_lowered();
        send_request(ACT_ALLOC, 21'd40, 4'd3);
        write_register(REG_CAPACITY_BYTES, 32'd0);
        send_request(ACT_ALLOC, 21'd0, 4'd0);
        send_request(ACT_POP, 21'd0, 4'd0);
        send_request(ACT_ALLOC, 21'd1, 4'd6);
        write_register(REG_CAPACITY_BYTES, 32'd1048576);
    endtask

    // fill the offset stack, overflow it once, free one slot and refill it, then empty it and pop once more
    task automatic test_stack_full();
        write_register(REG_BASE_ADDRESS, 32'd0);
        while (live_depth < MAX_LIVE)
            send_request(ACT_ALLOC, 21'd0, 4'd0);
        send_request(ACT_ALLOC, 21'd1, 4'd3);
        send_request(ACT_POP, 21'd0, 4'd0);
        send_request(ACT_ALLOC, 21'd2, 4'd9);
        while (live_depth > 0)
            send_request(ACT_POP, 21'd0, 4'd0);
        send_request(ACT_POP, 21'd0, 4'd0);
    endtask

    // random traffic under one configuration
    task automatic run_random_phase(input int n_items, input int pop_pct);
        logic [OFF_W-1:0] bytes;
        int               pick;
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                bytes = OFF_W'($urandom_range(0, 255));
            else if (pick < 95)
                bytes = OFF_W'($urandom_range(0, 8192));
            else
                bytes = OFF_W'($urandom);
            if ($urandom_range(0, 79) == 0)
                drain_results();
            send_request(($urandom_range(0, 99) < pop_pct) ? ACT_POP : ACT_ALLOC,
                         bytes, LG_W'($urandom_range(0, 15)));
        end
    endtask

    task automatic test_random_traffic();
        write_register(REG_BASE_ADDRESS, 32'hFFFF_FFFF);
        write_register(REG_CAPACITY_BYTES, 32'd1048576);
        run_random_phase(90, 30);
        write_register(REG_BASE_ADDRESS, 32'd0);
        write_register(REG_CAPACITY_BYTES, $urandom_range(200, 4000));
        run_random_phase(90, 45);
        write_register(REG_CAPACITY_BYTES, 32'd0);
        run_random_phase(20, 50);
        write_register(REG_BASE_ADDRESS, $urandom);
        write_register(REG_CAPACITY_BYTES, $urandom_range(0, 1048576));
        run_random_phase(80, 35);
        write_register(REG_BASE_ADDRESS, $urandom);
        write_register(REG_CAPACITY_BYTES, 32'd65536);
        run_random_phase(80, 30);
        write_register(REG_BASE_ADDRESS, $urandom);
        write_register(REG_CAPACITY_BYTES, 32'd1048576);
        run_random_phase(80, 40);
    endtask

    // test sequence
    initial begin
        apply_reset();
        test_pop_on_empty();
        test_alignment_clamp();
        test_capacity_edge();
        test_address_wrap();
        test_capacity_lowered();
        test_stack_full();
        test_random_traffic();
        drain_results();
        repeat (20) @(posedge i_clk);
        if (pending_results.size() != 0)
            errors++;
        $display("%0d transactions sent, %0d results checked, %0d mismatches",
                 n_sent, n_checked, errors);
        $display("ok %0d, out of memory %0d, pop on empty %0d, stack full %0d",
                 status_seen[ST_OK], status_seen[ST_NOMEM], status_seen[ST_EMPTY],
                 status_seen[ST_FULL]);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
